@@ rtl/core/sll_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sll_pkg
// Shared types, codes and defaults for the static linked list engine: request
// codes, fixed field widths, controller states and the command and status
// groups between controller and datapath.
// ----------------------------------------------------------------------------
package sll_pkg;

  // Default sizes
  localparam int SLOTS_DEF      = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths on the channels
  localparam int REQ_W     = 2;
  localparam int POS_W     = 10;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 32;
  localparam int LEN_W     = 10;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  // Result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_ALLOC,
    ST_WALK,
    ST_INS_LINK,
    ST_DEL_UNLINK,
    ST_DEL_FREE,
    ST_RD_DATA,
    ST_FINISH
  } state_t;

  // Link memory read address source
  typedef enum logic [1:0] {
    LRD_NONE,
    LRD_HEAD,
    LRD_FREE,
    LRD_LINKQ
  } link_rd_t;

  // Link memory write: which entry gets which value
  typedef enum logic [2:0] {
    LWR_NONE,
    LWR_CLEAR,
    LWR_J_LINKQ,
    LWR_K_J,
    LWR_K_LINKQ,
    LWR_J_FREE
  } link_wr_t;

  // Element memory read address source
  typedef enum logic [1:0] {
    ERD_NONE,
    ERD_LINKQ,
    ERD_J
  } elem_rd_t;

  // Controller to datapath
  typedef struct packed {
    logic     latch_req;
    logic     clr_step;
    link_rd_t link_rd;
    link_wr_t link_wr;
    logic     elem_wr;
    elem_rd_t elem_rd;
    logic     k_head;
    logic     k_linkq;
    logic     j_free;
    logic     j_linkq;
    logic     free_linkq;
    logic     free_j;
    logic     steps_load;
    logic     steps_dec;
    logic     set_err;
    logic     dout_load;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             clear_done;
    logic             req_ok;
    logic             steps_zero;
    logic             out_busy;
    logic [REQ_W-1:0] req;
  } dp_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/sll_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sll_req_if
// Request channel: valid/ready handshake with request code, position and data.
// ----------------------------------------------------------------------------
interface sll_req_if;
  logic                         valid;
  logic                         ready;
  logic [sll_pkg::REQ_W-1:0]     req_type;
  logic [sll_pkg::POS_W-1:0]     position;
  logic [sll_pkg::IN_DATA_W-1:0] data_in;

  modport source (output valid, output req_type, output position, output data_in,
                  input ready);
  modport sink (input valid, input req_type, input position, input data_in,
                output ready);
endinterface
`default_nettype wire

@@ rtl/core/sll_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sll_rsp_if
// Result channel: valid/ready handshake with status, data and list length.
// ----------------------------------------------------------------------------
interface sll_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [sll_pkg::OUT_DATA_W-1:0] data_out;
  logic [sll_pkg::LEN_W-1:0]      list_length;

  modport source (output valid, output status, output data_out, output list_length,
                  input ready);
  modport sink (input valid, input status, input data_out, input list_length,
                output ready);
endinterface
`default_nettype wire

@@ rtl/core/sll_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sll_ctrl
// Request sequencer: runs the clearing pass, checks each request, walks the
// link chain one entry per cycle and issues the relink and result steps.
// ----------------------------------------------------------------------------
module sll_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire sll_pkg::dp_sts_t  sts,
  output sll_pkg::dp_cmd_t       cmd
);
  import sll_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        cmd.link_wr  = LWR_CLEAR;
        if (sts.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_nxt     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts.req_ok) begin
          cmd.set_err = 1'b1;
          state_nxt   = ST_FINISH;
        end else begin
          cmd.steps_load = 1'b1;
          cmd.k_head     = 1'b1;
          if (sts.req == REQ_INSERT) begin
            // take the first free slot and store the data there
            cmd.link_rd = LRD_FREE;
            cmd.elem_wr = 1'b1;
            cmd.j_free  = 1'b1;
            state_nxt   = ST_ALLOC;
          end else begin
            cmd.link_rd = LRD_HEAD;
            state_nxt   = ST_WALK;
          end
        end
      end
      ST_ALLOC: begin
        cmd.free_linkq = 1'b1;
        cmd.link_rd    = LRD_HEAD;
        state_nxt      = ST_WALK;
      end
      ST_WALK: begin
        if (sts.steps_zero) begin
          // predecessor reached; read data holds its successor link
          case (sts.req)
            REQ_INSERT: begin
              cmd.link_wr = LWR_J_LINKQ;
              state_nxt   = ST_INS_LINK;
            end
            REQ_DELETE: begin
              cmd.j_linkq = 1'b1;
              cmd.link_rd = LRD_LINKQ;
              state_nxt   = ST_DEL_UNLINK;
            end
            default: begin
              cmd.elem_rd = ERD_LINKQ;
              state_nxt   = ST_RD_DATA;
            end
          endcase
        end else begin
          // advance one link
          cmd.k_linkq   = 1'b1;
          cmd.link_rd   = LRD_LINKQ;
          cmd.steps_dec = 1'b1;
        end
      end
      ST_INS_LINK: begin
        cmd.link_wr = LWR_K_J;
        cmd.cnt_inc = 1'b1;
        state_nxt   = ST_FINISH;
      end
      ST_DEL_UNLINK: begin
        cmd.link_wr = LWR_K_LINKQ;
        cmd.elem_rd = ERD_J;
        state_nxt   = ST_DEL_FREE;
      end
      ST_DEL_FREE: begin
        // return the slot to the head of the free chain
        cmd.link_wr   = LWR_J_FREE;
        cmd.free_j    = 1'b1;
        cmd.dout_load = 1'b1;
        cmd.cnt_dec   = 1'b1;
        state_nxt     = ST_FINISH;
      end
      ST_RD_DATA: begin
        cmd.dout_load = 1'b1;
        state_nxt     = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/sll_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sll_dp
// Datapath: link and element memories, walk pointers, free-chain head,
// element count, position checks and the result register.
// ----------------------------------------------------------------------------
module sll_dp #(
  parameter int SLOTS      = sll_pkg::SLOTS_DEF,
  parameter int DATA_WIDTH = sll_pkg::DATA_WIDTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire sll_pkg::dp_cmd_t            cmd,
  output sll_pkg::dp_sts_t                 sts,
  input  wire [sll_pkg::REQ_W-1:0]         in_req_type,
  input  wire [sll_pkg::POS_W-1:0]         in_position,
  input  wire [sll_pkg::IN_DATA_W-1:0]     in_data_in,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             out_status,
  output logic [sll_pkg::OUT_DATA_W-1:0]   out_data_out,
  output logic [sll_pkg::LEN_W-1:0]        out_list_length
);
  import sll_pkg::*;

  localparam int SW   = $clog2(SLOTS);
  localparam int CMPW = ((SW > POS_W) ? SW : POS_W) + 1;
  localparam logic [SW-1:0] HEAD_SLOT = SW'(SLOTS - 1);
  localparam logic [SW-1:0] LAST_FREE = SW'(SLOTS - 2);
  localparam logic [SW-1:0] NULL_SLOT = '0;
  localparam logic [SW-1:0] FIRST_FREE = SW'(1);

  // Memories
  logic [SW-1:0]         link_mem [SLOTS];
  logic [DATA_WIDTH-1:0] elem_mem [SLOTS];

  // Request and walk registers
  logic [REQ_W-1:0]      req_r;
  logic [POS_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] din_r;
  logic [SW-1:0]         k_r, j_r, free_r, steps_r, count_r, clr_r;
  logic [SW-1:0]         link_q;
  logic [DATA_WIDTH-1:0] elem_q;
  logic                  err_r;
  logic [DATA_WIDTH-1:0] dout_r;
  logic                  out_valid_r, out_status_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [LEN_W-1:0]      out_len_r;

  logic                  link_rd_en, link_wr_en, elem_rd_en;
  logic [SW-1:0]         link_rd_addr, link_wr_addr, link_wr_data, elem_rd_addr;
  logic [CMPW-1:0]       pos_ext, cnt_ext;
  logic                  pos_nz;

  // Position checks
  assign pos_ext = CMPW'(pos_r);
  assign cnt_ext = CMPW'(count_r);
  assign pos_nz  = (pos_r != '0);

  // Status to the controller
  always_comb begin
    sts.clear_done = (clr_r == HEAD_SLOT);
    sts.steps_zero = (steps_r == '0);
    sts.out_busy   = out_valid_r & ~out_ready;
    sts.req        = req_r;
    case (req_r)
      REQ_INSERT: sts.req_ok = pos_nz && (pos_ext <= cnt_ext + CMPW'(1)) &&
                               (free_r != NULL_SLOT);
      REQ_DELETE: sts.req_ok = pos_nz && (pos_ext <= cnt_ext);
      REQ_READ:   sts.req_ok = pos_nz && (pos_ext <= cnt_ext);
      default:    sts.req_ok = 1'b0;
    endcase
  end

  // Link memory read address
  always_comb begin
    link_rd_en   = 1'b1;
    link_rd_addr = link_q;
    case (cmd.link_rd)
      LRD_HEAD:  link_rd_addr = HEAD_SLOT;
      LRD_FREE:  link_rd_addr = free_r;
      LRD_LINKQ: link_rd_addr = link_q;
      default:   link_rd_en   = 1'b0;
    endcase
  end

  // Link memory write address and data
  always_comb begin
    link_wr_en   = 1'b1;
    link_wr_addr = k_r;
    link_wr_data = j_r;
    case (cmd.link_wr)
      LWR_CLEAR: begin
        link_wr_addr = clr_r;
        link_wr_data = (clr_r < LAST_FREE) ? clr_r + SW'(1) : NULL_SLOT;
      end
      LWR_J_LINKQ: begin
        link_wr_addr = j_r;
        link_wr_data = link_q;
      end
      LWR_K_J: begin
        link_wr_addr = k_r;
        link_wr_data = j_r;
      end
      LWR_K_LINKQ: begin
        link_wr_addr = k_r;
        link_wr_data = link_q;
      end
      LWR_J_FREE: begin
        link_wr_addr = j_r;
        link_wr_data = free_r;
      end
      default: link_wr_en = 1'b0;
    endcase
  end

  // Element memory read address
  always_comb begin
    elem_rd_en   = 1'b1;
    elem_rd_addr = j_r;
    case (cmd.elem_rd)
      ERD_LINKQ: elem_rd_addr = link_q;
      ERD_J:     elem_rd_addr = j_r;
      default:   elem_rd_en   = 1'b0;
    endcase
  end

  // Link memory
  always_ff @(posedge clk) begin
    if (link_wr_en) begin
      link_mem[link_wr_addr] <= link_wr_data;
    end
    if (link_rd_en) begin
      link_q <= link_mem[link_rd_addr];
    end
  end

  // Element memory
  always_ff @(posedge clk) begin
    if (cmd.elem_wr) begin
      elem_mem[free_r] <= din_r;
    end
    if (elem_rd_en) begin
      elem_q <= elem_mem[elem_rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      free_r      <= FIRST_FREE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step && (clr_r != HEAD_SLOT)) begin
        clr_r <= clr_r + SW'(1);
      end
      if (cmd.free_linkq) begin
        free_r <= link_q;
      end else if (cmd.free_j) begin
        free_r <= j_r;
      end
      if (cmd.cnt_inc) begin
        count_r <= count_r + SW'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - SW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_r  <= in_req_type;
      pos_r  <= in_position;
      din_r  <= DATA_WIDTH'(64'(in_data_in));
      err_r  <= STATUS_OK;
      dout_r <= '0;
    end
    if (cmd.set_err) begin
      err_r <= STATUS_ERR;
    end
    if (cmd.dout_load) begin
      dout_r <= elem_q;
    end
    if (cmd.steps_load) begin
      steps_r <= SW'(pos_ext - CMPW'(1));
    end else if (cmd.steps_dec) begin
      steps_r <= steps_r - SW'(1);
    end
    if (cmd.k_head) begin
      k_r <= HEAD_SLOT;
    end else if (cmd.k_linkq) begin
      k_r <= link_q;
    end
    if (cmd.j_free) begin
      j_r <= free_r;
    end else if (cmd.j_linkq) begin
      j_r <= link_q;
    end
    if (cmd.out_load) begin
      out_status_r <= err_r;
      out_data_r   <= OUT_DATA_W'(64'(dout_r));
      out_len_r    <= LEN_W'(cnt_ext);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_data_out    = out_data_r;
  assign out_list_length = out_len_r;

endmodule
`default_nettype wire

@@ rtl/core/static_linked_list_engine_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// static_linked_list_engine_core
// Array-based linked list with a free chain. Requests insert, delete or read
// the element at a one-based position; one result item per request.
// ----------------------------------------------------------------------------
// Channels: in_ch takes a request item (req_type, position, data_in) with a
// valid/ready handshake; out_ch returns one result item (status, data_out,
// list_length) per request through an output register.
// Sequence: a read walks the chain to position p and loads the result
// register; insert adds slot allocation and delete adds unlink and free,
// while a rejected request goes from the check to the result. The chain
// walk follows one link per cycle through the single read port of the
// link memory. One request is in work at a time; the next is accepted
// the cycle after the result is loaded, even while out_ch is still
// stalled.
// Reset: after rst_n is released the link memory is initialized by a sweep
// over every slot, during which in_ch.ready stays low. The list is then
// empty and all slots but the head and null slot 0 lie on the free chain.
// Stall: a stalled out_ch holds its result; a finished request waits for the
// output register before the engine takes the next request.
// Errors (bad position, full list, unknown code) leave the list unchanged.
// ----------------------------------------------------------------------------
module static_linked_list_engine_core #(
  parameter int SLOTS      = sll_pkg::SLOTS_DEF,
  parameter int DATA_WIDTH = sll_pkg::DATA_WIDTH_DEF
) (
  input wire          clk,
  input wire          rst_n,
  sll_req_if.sink     in_ch,
  sll_rsp_if.source   out_ch
);
  import sll_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  sll_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Memories and registers
  sll_dp #(
    .SLOTS      (SLOTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_ch.req_type),
    .in_position     (in_ch.position),
    .in_data_in      (in_ch.data_in),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_data_out    (out_ch.data_out),
    .out_list_length (out_ch.list_length)
  );

endmodule
`default_nettype wire

@@ sim/static_linked_list_engine_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// static_linked_list_engine_core_tb
// Self-checking bench for the linked list engine. Requests go in through the
// request channel and every result item is checked field by field against a
// behavioral copy of the list (link array, element array and length). The run
// covers edge positions, every request code, a long list with deep walks and
// several phases of random traffic with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module static_linked_list_engine_core_tb;
  import sll_pkg::*;

  localparam int LIST_SLOTS = SLOTS_DEF;
  localparam int HEAD_SLOT  = LIST_SLOTS - 1;
  localparam int LONG_LEN   = 100;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic                  status;
    logic [OUT_DATA_W-1:0] data;
    logic [LEN_W-1:0]      length;
  } list_result_t;

  logic clk;
  logic rst_n;

  sll_req_if req_ch ();
  sll_rsp_if rsp_ch ();

  static_linked_list_engine_core u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_ch),
    .out_ch(rsp_ch)
  );

  // Shadow copy of the list
  logic [POS_W-1:0]     link_mem [LIST_SLOTS];
  logic [IN_DATA_W-1:0] elem_mem [LIST_SLOTS];
  int                   elem_count;

  list_result_t pending_results[$];
  int           error_count;
  int           send_idle_pct;
  int           sink_stall_pct;

  // Clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Follow a number of links starting at the list head
  function automatic logic [POS_W-1:0] walk_links(int steps);
    logic [POS_W-1:0] slot;
    slot = POS_W'(HEAD_SLOT);
    for (int i = 0; i < steps; i++) slot = link_mem[slot];
    return slot;
  endfunction

  // Apply one request to the shadow list and return its result
  function automatic list_result_t apply_request(logic [REQ_W-1:0] kind,
                                                 logic [POS_W-1:0] pos,
                                                 logic [IN_DATA_W-1:0] din);
    list_result_t res;
    logic [POS_W-1:0] free_slot;
    logic [POS_W-1:0] prev_slot;
    int p;
    res.status = STATUS_ERR;
    res.data   = '0;
    p = int'(pos);
    case (kind)
      REQ_INSERT: begin
        free_slot = link_mem[0];
        if (p >= 1 && p <= elem_count + 1 && free_slot != 0) begin
          link_mem[0]         = link_mem[free_slot];
          elem_mem[free_slot] = din;
          prev_slot           = walk_links(p - 1);
          link_mem[free_slot] = link_mem[prev_slot];
          link_mem[prev_slot] = free_slot;
          elem_count++;
          res.status = STATUS_OK;
        end
      end
      REQ_DELETE: begin
        if (p >= 1 && p <= elem_count) begin
          prev_slot           = walk_links(p - 1);
          free_slot           = link_mem[prev_slot];
          link_mem[prev_slot] = link_mem[free_slot];
          link_mem[free_slot] = link_mem[0];
          link_mem[0]         = free_slot;
          elem_count--;
          res.data   = elem_mem[free_slot];
          res.status = STATUS_OK;
        end
      end
      REQ_READ: begin
        if (p >= 1 && p <= elem_count) begin
          res.data   = elem_mem[walk_links(p)];
          res.status = STATUS_OK;
        end
      end
      default: ;
    endcase
    res.length = elem_count[LEN_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t ns: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    error_count++;
  endtask

  // Send one request item; entered and left at a falling edge
  task automatic send_request(logic [REQ_W-1:0] kind, logic [POS_W-1:0] pos,
                              logic [IN_DATA_W-1:0] din);
    list_result_t want;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    req_ch.valid    = 1'b1;
    req_ch.req_type = kind;
    req_ch.position = pos;
    req_ch.data_in  = din;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    want = apply_request(kind, pos, din);
    pending_results.push_back(want);
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  // Hold the sender until every expected result has come back
  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Receiver stalls
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Check each result item against the oldest expectation
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result (status)", 32'd0, 32'(rsp_ch.status));
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(rsp_ch.status));
        if (rsp_ch.data_out !== want.data)
          report_mismatch("data_out", want.data, rsp_ch.data_out);
        if (rsp_ch.list_length !== want.length)
          report_mismatch("list_length", 32'(want.length), 32'(rsp_ch.list_length));
      end
    end
  end

  // Edge positions, every request code, empty-list errors
  task automatic test_directed();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    send_request(REQ_READ,   10'd1,    32'h0);
    send_request(REQ_DELETE, 10'd1,    32'h0);
    send_request(REQ_INSERT, 10'd0,    32'h1111_1111);
    send_request(REQ_INSERT, 10'd2,    32'h2222_2222);
    send_request(REQ_INSERT, 10'd1,    32'h0000_0000);
    send_request(REQ_INSERT, 10'd2,    32'hFFFF_FFFF);
    send_request(REQ_INSERT, 10'd1,    32'hA5A5_A5A5);
    send_request(REQ_INSERT, 10'd3,    32'h5A5A_5A5A);
    send_request(REQ_INSERT, 10'd1023, 32'h3333_3333);
    for (int p = 1; p <= 4; p++) send_request(REQ_READ, p[POS_W-1:0], 32'hDEAD_BEEF);
    send_request(REQ_READ,    10'd5,    32'h0);
    send_request(REQ_READ,    10'd0,    32'h0);
    send_request(REQ_READ,    10'd1023, 32'h0);
    send_request(REQ_UNKNOWN, 10'd1,    32'h4444_4444);
    send_request(REQ_DELETE,  10'd5,    32'h0);
    send_request(REQ_DELETE,  10'd0,    32'h0);
    // remove middle, last, then first element
    send_request(REQ_DELETE,  10'd2,    32'h0);
    send_request(REQ_DELETE,  10'd3,    32'h0);
    send_request(REQ_DELETE,  10'd1,    32'h0);
    send_request(REQ_READ,    10'd1,    32'h0);
    send_request(REQ_DELETE,  10'd1,    32'h0);
    wait_results_drained();
  endtask

  // Grow a long list at random positions, deep walks at its tail, then empty it
  task automatic test_long_list();
    send_idle_pct  = 10;
    sink_stall_pct = 10;
    for (int i = 0; i < LONG_LEN; i++)
      send_request(REQ_INSERT, POS_W'($urandom_range(elem_count + 1, 1)), $urandom);
    send_request(REQ_READ,   POS_W'(elem_count),     32'h0);
    send_request(REQ_READ,   POS_W'(elem_count + 1), 32'h0);
    send_request(REQ_INSERT, POS_W'(elem_count + 2), $urandom);
    send_request(REQ_DELETE, POS_W'(elem_count),     32'h0);
    send_request(REQ_INSERT, POS_W'(elem_count + 1), 32'hC3C3_C3C3);
    send_request(REQ_READ,   POS_W'(elem_count),     32'h0);
    wait_results_drained();
    while (elem_count > 0)
      send_request(REQ_DELETE, POS_W'($urandom_range(elem_count, 1)), 32'h0);
    wait_results_drained();
  endtask

  // Random mix with the list kept short so walks stay cheap
  task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
    logic [REQ_W-1:0] kind;
    logic [POS_W-1:0] pos;
    int ins_pct;
    int bound;
    int sel;
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      ins_pct = (elem_count < 8) ? 60 : (elem_count > 40) ? 25 : 42;
      sel = $urandom_range(99);
      if (sel < 4)                 kind = REQ_UNKNOWN;
      else if (sel < 4 + ins_pct)  kind = REQ_INSERT;
      else if (sel < 74)           kind = REQ_DELETE;
      else                         kind = REQ_READ;
      bound = (kind == REQ_INSERT) ? elem_count + 1 : elem_count;
      sel = $urandom_range(99);
      if (sel < 12)                   pos = POS_W'($urandom);
      else if (sel < 16)              pos = 10'd0;
      else if (sel < 20 || bound < 1) pos = POS_W'(bound + 1);
      else                            pos = POS_W'($urandom_range(bound, 1));
      send_request(kind, pos, $urandom);
    end
    wait_results_drained();
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_INSERT;
    req_ch.position = '0;
    req_ch.data_in  = '0;
    rsp_ch.ready    = 1'b0;
    error_count     = 0;
    send_idle_pct   = 0;
    sink_stall_pct  = 0;
    elem_count      = 0;
    for (int i = 0; i < LIST_SLOTS; i++) begin
      link_mem[i] = (i + 2 < LIST_SLOTS) ? POS_W'(i + 1) : '0;
      elem_mem[i] = '0;
    end
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_long_list();
    test_random_traffic(88, 0, 0);
    test_random_traffic(88, 45, 0);
    test_random_traffic(88, 0, 45);
    test_random_traffic(88, 34, 34);

    // let a late or stray result show up
    wait_results_drained();
    repeat (LIST_SLOTS + 8) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit
  initial begin
    #500ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/sll_pkg.sv
rtl/core/sll_req_if.sv
rtl/core/sll_rsp_if.sv
rtl/core/sll_ctrl.sv
rtl/core/sll_dp.sv
rtl/core/static_linked_list_engine_core.sv
sim/static_linked_list_engine_core_tb.sv
